/* src/sha_pkg.sv */
// Shared constants, types and round functions for the SHA-256 byte stream hasher.
package sha_pkg;

   localparam int WordBits   = 32;
   localparam int BlockWords = 16;
   localparam int ChainWords = 8;
   localparam int RoundCount = 64;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef logic [WordBits-1:0] word_type;

   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type choose(word_type e, word_type f, word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(word_type a, word_type b, word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic word_type init_hash(logic [2:0] idx);
      word_type h;
      unique case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         3'd7: h = 32'h5be0cd19;
         default: h = 32'h6a09e667;
      endcase
      return h;
   endfunction

   function automatic word_type round_k(logic [5:0] r);
      word_type k;
      unique case (r)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h428a2f98;
      endcase
      return k;
   endfunction

endpackage

/* src/sha_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/sha256_byte_stream_hasher.sv */
// SHA-256 hasher that takes a message one byte per beat and returns the digest in eight beats.
//
// The request channel carries one beat per message byte (req_op absorb) or one beat that
// ends the message (req_op finish). The response channel returns the eight digest words,
// word 0 first, with rsp_last_word set on the eighth.
// Every 64th byte starts a compression of the buffered block: the schedule and working
// variables are loaded from the block and chain memories, the rounds run through the
// single round unit, and a read-modify-write pass updates the chain memory; during all
// of this req_ready is low.
// A finish beat writes the padding one byte per cycle (64 minus the fill count), runs one
// compression, or two when the length field does not fit in the current block, and then
// reads the eight digest words out of the chain memory, each through a read and a load state.
// The response sits in an output register; the block stalls only when it has the next digest
// word to hand over before the last is taken, and accepts beats while the final word waits.
// Reset empties the block buffer, clears the bit count and marks every chain memory entry
// as unwritten, so that it reads as the standard initial hash value; no clearing pass runs.
// After the last digest word the chain entries return to that state for the next message.
module sha256_byte_stream_hasher (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic [7:0]              req_byte_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sha_pkg::word_type       rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PAD     = 3'd1;
   localparam logic [2:0] ST_LOAD    = 3'd2;
   localparam logic [2:0] ST_ROUND   = 3'd3;
   localparam logic [2:0] ST_UPDATE  = 3'd4;
   localparam logic [2:0] ST_EMIT_RD = 3'd5;
   localparam logic [2:0] ST_EMIT_LD = 3'd6;

   localparam logic [5:0] FillLast   = 6'd63;
   localparam logic [5:0] LenFirst   = 6'd56;
   localparam logic [5:0] LoadLast   = 6'(BlockWords);
   localparam logic [5:0] RoundLast  = 6'(RoundCount - 1);
   localparam logic [5:0] UpdateLast = 6'(ChainWords);
   localparam logic [5:0] EmitLast   = 6'(ChainWords - 1);
   localparam logic [63:0] BlockBits = 64'd512;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] len_ff, len_in;
   logic [23:0] acc_ff, acc_in;
   logic        pad_ff, pad_in;
   logic        mark_ff, mark_in;
   logic        extra_ff, extra_in;
   logic [ChainWords-1:0] chain_vld_ff, chain_vld_in;
   logic [2:0]  crd_idx_ff;
   logic        crd_vld_ff;

   word_type    var_ff [ChainWords];
   word_type    var_in [ChainWords];
   word_type    sched_ff [BlockWords];
   word_type    sched_in [BlockWords];

   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_word_ff;
   logic [2:0]  rsp_idx_ff;
   logic        rsp_last_ff;
   logic        rsp_load;

   logic        byte_take;
   logic [7:0]  pad_byte;
   logic [7:0]  in_byte;
   logic        buf_we;
   word_type    buf_wdata;
   word_type    buf_q;
   logic [2:0]  chain_raddr;
   logic        chain_we;
   logic [2:0]  chain_waddr;
   word_type    chain_wdata;
   word_type    chain_ram_q;
   word_type    chain_q;
   word_type    t1;
   word_type    t2;
   word_type    next_w;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

   always_comb begin
      priority if (!mark_ff) begin
         pad_byte = 8'h80;
      end else if (!extra_ff && fill_ff >= LenFirst) begin
         pad_byte = len_ff[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign byte_take = (state_ff == ST_PAD) ||
                      (state_ff == ST_IDLE && req_valid && req_op == OP_ABSORB);
   assign in_byte   = (state_ff == ST_PAD) ? pad_byte : req_byte_value;
   assign buf_we    = byte_take && (fill_ff[1:0] == 2'b11);
   assign buf_wdata = {acc_ff, in_byte};
   assign acc_in    = byte_take ? {acc_ff[15:0], in_byte} : acc_ff;

   sha_ram #(
      .WIDTH(WordBits),
      .DEPTH(BlockWords)
   ) u_block_ram (
      .clock  (clock),
      .wr_en  (buf_we),
      .wr_addr(fill_ff[5:2]),
      .wr_data(buf_wdata),
      .rd_addr(cnt_ff[3:0]),
      .rd_data(buf_q)
   );

   assign chain_raddr = (state_ff == ST_LOAD) ? (3'd7 - cnt_ff[2:0]) : cnt_ff[2:0];
   assign chain_we    = (state_ff == ST_UPDATE) && (cnt_ff != 6'd0);
   assign chain_waddr = cnt_ff[2:0] - 3'd1;
   assign chain_q     = crd_vld_ff ? chain_ram_q : init_hash(crd_idx_ff);
   assign chain_wdata = chain_q + var_ff[0];

   sha_ram #(
      .WIDTH(WordBits),
      .DEPTH(ChainWords)
   ) u_chain_ram (
      .clock  (clock),
      .wr_en  (chain_we),
      .wr_addr(chain_waddr),
      .wr_data(chain_wdata),
      .rd_addr(chain_raddr),
      .rd_data(chain_ram_q)
   );

   assign t1 = var_ff[7] + big_sigma1(var_ff[4]) + choose(var_ff[4], var_ff[5], var_ff[6]) +
               round_k(cnt_ff) + sched_ff[0];
   assign t2 = big_sigma0(var_ff[0]) + majority(var_ff[0], var_ff[1], var_ff[2]);
   assign next_w = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1]) +
                   sched_ff[0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      extra_in     = extra_ff;
      chain_vld_in = chain_vld_ff;
      rsp_load     = 1'b0;

      if (chain_we) begin
         chain_vld_in[chain_waddr] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ABSORB) begin
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == FillLast) begin
                     total_in = total_ff + BlockBits;
                     cnt_in   = 6'd0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  len_in   = total_ff + {55'd0, fill_ff, 3'b000};
                  pad_in   = 1'b1;
                  mark_in  = 1'b0;
                  extra_in = 1'b0;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            fill_in = fill_ff + 6'd1;
            if (!mark_ff) begin
               mark_in  = 1'b1;
               extra_in = (fill_ff >= LenFirst);
            end else if (!extra_ff && fill_ff >= LenFirst) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (fill_ff == FillLast) begin
               cnt_in   = 6'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LoadLast) begin
               cnt_in   = 6'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == RoundLast) begin
               cnt_in   = 6'd0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == UpdateLast) begin
               cnt_in = 6'd0;
               priority if (!pad_ff) begin
                  state_in = ST_IDLE;
               end else if (extra_ff) begin
                  extra_in = 1'b0;
                  state_in = ST_PAD;
               end else begin
                  total_in = 64'd0;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            rsp_load = 1'b1;
            if (cnt_ff == EmitLast) begin
               cnt_in       = 6'd0;
               pad_in       = 1'b0;
               chain_vld_in = '0;
               state_in     = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 6'd1;
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      var_in   = var_ff;
      sched_in = sched_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (cnt_ff != 6'd0) begin
               for (int i = 0; i < BlockWords - 1; i++) begin
                  sched_in[i] = sched_ff[i+1];
               end
               sched_in[BlockWords-1] = buf_q;
            end
            if (cnt_ff != 6'd0 && cnt_ff <= 6'(ChainWords)) begin
               for (int i = 1; i < ChainWords; i++) begin
                  var_in[i] = var_ff[i-1];
               end
               var_in[0] = chain_q;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < BlockWords - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[BlockWords-1] = next_w;
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
         end
         ST_UPDATE: begin
            if (cnt_ff != 6'd0) begin
               for (int i = 0; i < ChainWords - 1; i++) begin
                  var_in[i] = var_ff[i+1];
               end
               var_in[ChainWords-1] = var_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 6'd0;
         fill_ff      <= 6'd0;
         total_ff     <= 64'd0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         extra_ff     <= 1'b0;
         chain_vld_ff <= '0;
         crd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         extra_ff     <= extra_in;
         chain_vld_ff <= chain_vld_in;
         crd_vld_ff   <= chain_vld_ff[chain_raddr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      acc_ff     <= acc_in;
      crd_idx_ff <= chain_raddr;
      var_ff     <= var_in;
      sched_ff   <= sched_in;
      if (rsp_load) begin
         rsp_word_ff <= chain_q;
         rsp_idx_ff  <= cnt_ff[2:0];
         rsp_last_ff <= (cnt_ff == EmitLast);
      end
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT_LD)
      else $error("Response became valid outside the digest readout.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_LD |-> !rsp_valid_ff)
      else $error("Digest word loaded over a response still waiting.");

   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && cnt_ff == 6'd0) |-> fill_ff == 6'd0)
      else $error("Compression started on a partial block.");

   a_chain_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD && cnt_ff == EmitLast) |=> chain_vld_ff == '0)
      else $error("Chain state not returned to the initial values after a digest.");

endmodule
